// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: sv/bmau_pkg.sv
// ----------------------------------------------------------------------------
// bmau_pkg
// Shared types and codes of the byte memory access unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmau_pkg;

    // Access mode as it arrives on the input word
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_BOTH  = 2'd3
    } mode_t;

    // Result status
    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_BOUNDS  = 2'd1,
        ERR_ILLEGAL = 2'd2
    } err_t;

    // What the back end has to do with the memory
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Number of byte lanes (one bank per lane)
    localparam int unsigned LANES     = 4;
    localparam int unsigned MAX_LEN   = 4;

    // Queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // Classified access handed from front to back end
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] write_data;
        logic [2:0]  len;
        kind_t       kind;
        err_t        err;
        logic        to_reg;
    } op_t;

endpackage

`default_nettype wire

// File: sv/bmau_fifo.sv
// ----------------------------------------------------------------------------
// bmau_fifo
// Short queue of classified accesses between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmau_fifo
    import bmau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_op,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output op_t       head_op
);

    op_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    // Status and head of queue
    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming access
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: sv/bmau_front.sv
// ----------------------------------------------------------------------------
// bmau_front
// Classifies an incoming access: length clamp, mode decode, bound check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmau_front
    import bmau_pkg::*;
#(
    parameter int unsigned MEM_BYTES = 65536
)
(
    input  wire logic [31:0] address,
    input  wire logic [31:0] write_data,
    input  wire logic [1:0]  mode,
    input  wire logic        mem_to_reg,
    input  wire logic [2:0]  access_bytes,
    output op_t              op
);

    logic [2:0]  len;
    logic [32:0] end_addr;
    logic        oob;

    // Clamp the length and form the unwrapped end address
    always_comb
    begin
        len      = (access_bytes > 3'(MAX_LEN)) ? 3'(MAX_LEN) : access_bytes;
        end_addr = {1'b0, address} + {30'b0, len};
        oob      = (end_addr > 33'(MEM_BYTES));
    end

    // Decode the mode into work for the back end
    always_comb
    begin
        op.address    = address;
        op.write_data = write_data;
        op.len        = len;
        op.to_reg     = mem_to_reg;
        op.kind       = KIND_NONE;
        op.err        = ERR_OK;
        case (mode_t'(mode))
            MODE_NONE:
            begin
                op.kind = KIND_NONE;
            end
            MODE_READ:
            begin
                if (oob)
                begin
                    op.err = ERR_BOUNDS;
                end
                else
                begin
                    op.kind = KIND_READ;
                end
            end
            MODE_WRITE:
            begin
                if (oob)
                begin
                    op.err = ERR_BOUNDS;
                end
                else
                begin
                    op.kind = KIND_WRITE;
                end
            end
            MODE_BOTH:
            begin
                op.err = ERR_ILLEGAL;
            end
            default:
            begin
                op.kind = KIND_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/bmau_bank.sv
// ----------------------------------------------------------------------------
// bmau_bank
// One byte-wide memory bank with a single port and registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmau_bank
#(
    parameter int unsigned DEPTH = 16384
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [7:0]               wdata,
    output logic [7:0]                    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write or read one byte per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/bmau_back.sv
// ----------------------------------------------------------------------------
// bmau_back
// Carries out accesses on four byte banks and registers the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmau_back
    import bmau_pkg::*;
#(
    parameter int unsigned MEM_BYTES = 65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        op_valid,
    input  op_t              op,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_value,
    output logic [1:0]       out_err
);

    localparam int unsigned AW    = $clog2(MEM_BYTES);
    localparam int unsigned ROWS  = (MEM_BYTES + LANES - 1) / LANES;
    localparam int unsigned ROW_W = AW - 2;

    logic [LANES-1:0][7:0] bank_rdata;

    // Access stage
    logic        s1_valid_reg, s1_valid_next;
    kind_t       s1_kind_reg;
    err_t        s1_err_reg;
    logic        s1_to_reg_reg;
    logic [31:0] s1_addr_reg;
    logic [2:0]  s1_len_reg;
    logic        s1_move;

    // Output stage
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg;
    logic [1:0]  out_err_reg;

    logic [31:0] rdata;
    logic [31:0] result;

    // Take from the queue when the access stage is free or moving on
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop     = op_valid && (!s1_valid_reg || s1_move);

    // One bank per byte lane
    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        logic [1:0]       lane;
        logic             hit;
        logic [AW-1:0]    byte_addr;
        logic [ROW_W-1:0] row;
        logic [1:0]       shift;
        logic [7:0]       wbyte;

        // Map this bank onto a byte of the access
        always_comb
        begin
            lane      = 2'(b) - op.address[1:0];
            hit       = ({1'b0, lane} < op.len);
            byte_addr = op.address[AW-1:0] + AW'(lane);
            row       = byte_addr[AW-1:2];
            shift     = 2'(op.len - 3'd1 - {1'b0, lane});
            wbyte     = op.write_data[{shift, 3'b000} +: 8];
        end

        bmau_bank #(
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .en    (pop && hit && (op.kind != KIND_NONE)),
            .we    (op.kind == KIND_WRITE),
            .addr  (row),
            .wdata (wbyte),
            .rdata (bank_rdata[b])
        );
    end

    // Gather read bytes, most significant byte at the lowest address
    always_comb
    begin
        logic [2:0] idx;
        logic [1:0] bank;
        rdata = '0;
        for (int p = 0; p < LANES; p++)
        begin
            idx  = s1_len_reg - 3'd1 - 3'(p);
            bank = s1_addr_reg[1:0] + idx[1:0];
            if (3'(p) < s1_len_reg)
            begin
                rdata[p*8 +: 8] = bank_rdata[bank];
            end
        end
    end

    // Choose the result word
    always_comb
    begin
        if (s1_err_reg != ERR_OK)
        begin
            result = '0;
        end
        else if (s1_to_reg_reg)
        begin
            result = (s1_kind_reg == KIND_READ) ? rdata : '0;
        end
        else
        begin
            result = s1_addr_reg;
        end
    end

    assign s1_valid_next  = pop || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold access details while the banks answer
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_kind_reg   <= op.kind;
            s1_err_reg    <= op.err;
            s1_to_reg_reg <= op.to_reg;
            s1_addr_reg   <= op.address;
            s1_len_reg    <= op.len;
        end
        if (s1_move)
        begin
            out_value_reg <= result;
            out_err_reg   <= s1_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_err   = out_err_reg;

endmodule

`default_nettype wire

// File: sv/byte_memory_access_unit.sv
// ----------------------------------------------------------------------------
// byte_memory_access_unit
// Data-memory stage: byte-addressed big-endian memory, 1 to 4 byte accesses.
// ----------------------------------------------------------------------------
// The unit takes one access word per cycle while its queue is not full and
// returns one result word per access, in order. An access passes the front
// classifier and queue, then the four byte banks, each with a single
// registered read port, then the output register. Unaligned accesses reach
// their bytes in the banks in parallel, so alignment does not change the
// rate. Reads return zero-extended data, or the address when mem_to_reg is
// clear. An access whose end passes MEM_BYTES reports out of bounds, read
// with write together reports illegal, and neither touches memory. Bytes
// must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module byte_memory_access_unit
    import bmau_pkg::*;
#(
    parameter int unsigned MEM_BYTES = 65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Access word
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // address, write_data, access_bytes, zero pad
    input  wire logic [2:0]  s_axis_tuser,  // mode, mem_to_reg
    // Result word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // result_value
    output logic [1:0]       m_axis_tuser   // error_code
);

    op_t  front_op;
    op_t  head_op;
    logic queue_full;
    logic queue_not_empty;
    logic queue_pop;

    assign s_axis_tready = !queue_full;

    // Classify incoming words
    bmau_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .address      (s_axis_tdata[31:0]),
        .write_data   (s_axis_tdata[63:32]),
        .mode         (s_axis_tuser[1:0]),
        .mem_to_reg   (s_axis_tuser[2]),
        .access_bytes (s_axis_tdata[66:64]),
        .op           (front_op)
    );

    // Decouple front and back end
    bmau_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid && !queue_full),
        .push_op   (front_op),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_op   (head_op)
    );

    // Execute on the banks
    bmau_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_not_empty),
        .op        (head_op),
        .pop       (queue_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_err   (m_axis_tuser)
    );

    // No status code beyond illegal
    `ASSERT_NEVER(a_err_code_range, clk, rst_n, m_axis_tvalid && (m_axis_tuser == 2'd3))
    // Errors return a zero value
    `ASSERT_CLK(a_err_zero_value, clk, rst_n, (m_axis_tvalid && (m_axis_tuser != ERR_OK)) |-> (m_axis_tdata == '0))
    // Queue fills only on an accepted word
    `ASSERT_CLK(a_full_after_push, clk, rst_n, $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    // Nothing is taken from an empty queue
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, queue_pop && !queue_not_empty)

endmodule

`default_nettype wire

// File: test/tb_byte_memory_access_unit.sv
// ----------------------------------------------------------------------------
// tb_byte_memory_access_unit
// Self-checking bench for the byte memory access unit. Access words go in
// through the slave stream and are scored against a byte-level image of the
// memory kept in the bench. Directed corner cases run first, then random
// loads and stores into hot address windows, errored accesses and no-ops.
// Both stream sides stall at random in two of three idle mixes; the third has none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_byte_memory_access_unit;

    import bmau_pkg::*;

    localparam int unsigned MEM_SIZE        = 65536;
    localparam int unsigned STALL_LIMIT     = 20000;
    localparam int unsigned ITEMS_PER_PHASE = 584;
    localparam int unsigned DRAIN_CYCLES    = 8;

    // One access word as the bench sees it
    typedef struct {
        logic [31:0] address;
        logic [31:0] write_data;
        mode_t       mode;
        logic        to_reg;
        logic [2:0]  len;
    } access_t;

    // One result word as the unit should return it
    typedef struct {
        logic [31:0] value;
        err_t        status;
    } result_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // address, write_data, access_bytes, zero pad
    logic [2:0]  s_axis_tuser;   // mode, mem_to_reg
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // result_value
    logic [1:0]  m_axis_tuser;   // error_code

    // Byte image of the memory and which bytes have been stored so far
    logic [7:0]   mem_image [0:MEM_SIZE-1];
    bit           byte_known [0:MEM_SIZE-1];
    result_word_t result_words_due [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          error_count   = 0;
    int          words_sent    = 0;
    int          stall_cycles  = 0;
    int          status_seen [3];

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    byte_memory_access_unit #(
        .MEM_BYTES     (MEM_SIZE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clamp the byte count: 5 to 7 act as 4
    function automatic int unsigned effective_length(input logic [2:0] len);
        return (len > 3'd4) ? 4 : int'(len);
    endfunction

    // Work out the result of one access and update the memory image
    function automatic result_word_t apply_access(input access_t acc);
        result_word_t res;
        int unsigned  n;
        logic [63:0]  span_end;
        logic [31:0]  rdata;
        int unsigned  idx;
        n        = effective_length(acc.len);
        span_end = {32'd0, acc.address} + 64'(n);
        rdata    = '0;
        res.status = ERR_OK;
        if (acc.mode == MODE_BOTH)
        begin
            res.status = ERR_ILLEGAL;
        end
        else if (acc.mode == MODE_READ || acc.mode == MODE_WRITE)
        begin
            if (span_end > 64'(MEM_SIZE))
            begin
                res.status = ERR_BOUNDS;
            end
            else
            begin
                // Lowest address carries the most significant byte
                for (int i = 0; i < n; i++)
                begin
                    idx = acc.address + i;
                    if (acc.mode == MODE_READ)
                    begin
                        rdata = (rdata << 8) | 32'(mem_image[idx]);
                    end
                    else
                    begin
                        mem_image[idx]  = 8'(acc.write_data >> (8 * (n - 1 - i)));
                        byte_known[idx] = 1'b1;
                    end
                end
            end
        end
        if (res.status != ERR_OK)
            res.value = '0;
        else if (acc.to_reg)
            res.value = rdata;
        else
            res.value = acc.address;
        return res;
    endfunction

    // A load may go out only if it faults or every byte it touches is stored
    function automatic bit read_is_safe(input logic [31:0] addr, input logic [2:0] len);
        int unsigned n;
        n = effective_length(len);
        if ({32'd0, addr} + 64'(n) > 64'(MEM_SIZE))
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (!byte_known[addr + i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly the low bytes, some near the top end, a few anywhere
    function automatic logic [31:0] pick_address();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 6)
            return 32'($urandom_range(255));
        else if (k < 8)
            return 32'(MEM_SIZE - 1 - $urandom_range(259));
        else
            return 32'($urandom_range(MEM_SIZE - 1));
    endfunction

    // Mostly 1 to 4 bytes, sometimes zero or an oversized count
    function automatic logic [2:0] pick_length();
        int unsigned k;
        k = $urandom_range(19);
        if (k < 16)
            return 3'(1 + k % 4);
        case (k)
            16:      return 3'd0;
            17:      return 3'd5;
            18:      return 3'd6;
            default: return 3'd7;
        endcase
    endfunction

    // Offer one access word, wait for the handshake, queue its result
    task automatic send_access(input logic [31:0] addr, input logic [31:0] wdata,
                               input mode_t mode, input logic to_reg,
                               input logic [2:0] len);
        access_t acc;
        acc.address    = addr;
        acc.write_data = wdata;
        acc.mode       = mode;
        acc.to_reg     = to_reg;
        acc.len        = len;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {5'd0, len, wdata, addr};
        s_axis_tuser  <= {to_reg, mode};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        result_words_due.push_back(apply_access(acc));
        words_sent++;
    endtask

    // Stores and loads of every size, aligned and unaligned, odd byte counts
    task automatic test_aligned_and_unaligned();
        send_access(32'd0, 32'hA1B2_C3D4, MODE_WRITE, 1'b0, 3'd4);
        send_access(32'd0, 32'h0, MODE_READ, 1'b1, 3'd4);
        send_access(32'd1, 32'hFFFF_FF5A, MODE_WRITE, 1'b0, 3'd1);
        send_access(32'd1, 32'h0, MODE_READ, 1'b1, 3'd3);
        send_access(32'd4, 32'hFF12_3456, MODE_WRITE, 1'b1, 3'd3);
        send_access(32'd3, 32'h0, MODE_READ, 1'b1, 3'd4);
        send_access(32'd7, 32'h1234_BEEF, MODE_WRITE, 1'b0, 3'd2);
        send_access(32'd7, 32'h0, MODE_READ, 1'b0, 3'd2);
        send_access(32'd8, 32'h0, MODE_READ, 1'b1, 3'd1);
        send_access(32'd0, 32'h0, MODE_READ, 1'b1, 3'd0);
        send_access(32'd100, 32'hFFFF_FFFF, MODE_WRITE, 1'b0, 3'd0);
        send_access(32'd10, 32'h0102_0304, MODE_WRITE, 1'b0, 3'd7);
        send_access(32'd10, 32'h0, MODE_READ, 1'b1, 3'd5);
        send_access(32'd5, 32'h0, MODE_READ, 1'b1, 3'd6);
    endtask

    // Accesses at and past the top end, illegal mode and no-op words
    task automatic test_bounds_and_modes();
        send_access(32'(MEM_SIZE - 4), 32'hFFFF_FFFF, MODE_WRITE, 1'b0, 3'd4);
        send_access(32'(MEM_SIZE - 4), 32'h0, MODE_READ, 1'b1, 3'd4);
        send_access(32'(MEM_SIZE - 1), 32'h0, MODE_READ, 1'b1, 3'd1);
        send_access(32'(MEM_SIZE - 3), 32'h0, MODE_READ, 1'b1, 3'd4);
        send_access(32'(MEM_SIZE), 32'h0, MODE_READ, 1'b0, 3'd0);
        send_access(32'(MEM_SIZE), 32'h0, MODE_WRITE, 1'b0, 3'd1);
        send_access(32'hFFFF_FFFF, 32'h5555_AAAA, MODE_WRITE, 1'b0, 3'd4);
        send_access(32'hFFFF_FFFE, 32'h0, MODE_READ, 1'b1, 3'd4);
        send_access(32'd0, 32'hFFFF_FFFF, MODE_BOTH, 1'b1, 3'd4);
        send_access(32'hFFFF_FFFF, 32'h0, MODE_BOTH, 1'b0, 3'd7);
        send_access(32'hFFFF_FFFF, 32'h0, MODE_NONE, 1'b0, 3'd7);
        send_access(32'h0000_0004, 32'hFFFF_FFFF, MODE_NONE, 1'b1, 3'd4);
    endtask

    // Random loads, stores, faults and no-ops
    task automatic test_random_traffic(input int unsigned count);
        logic [31:0] addr;
        logic [2:0]  len;
        mode_t       mode;
        int unsigned pick;
        int unsigned tries;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            addr = pick_address();
            len  = pick_length();
            mode = MODE_WRITE;
            if (pick >= 40 && pick < 75)
            begin
                // Hunt for a load over stored bytes, else store there
                mode  = MODE_READ;
                tries = 0;
                while (!read_is_safe(addr, len) && tries < 16)
                begin
                    addr = pick_address();
                    len  = pick_length();
                    tries++;
                end
                if (!read_is_safe(addr, len))
                    mode = MODE_WRITE;
            end
            else if (pick >= 75 && pick < 83)
            begin
                addr = $urandom();
                mode = ($urandom_range(1) != 0) ? MODE_READ : MODE_WRITE;
                if (mode == MODE_READ && !read_is_safe(addr, len))
                    mode = MODE_WRITE;
            end
            else if (pick >= 83 && pick < 91)
            begin
                addr = $urandom();
                len  = 3'($urandom_range(7));
                mode = MODE_BOTH;
            end
            else if (pick >= 91)
            begin
                addr = $urandom();
                len  = 3'($urandom_range(7));
                mode = MODE_NONE;
            end
            send_access(addr, $urandom(), mode, $urandom_range(2) != 0, len);
        end
    endtask

    // Result side backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Score each result word against the oldest one due
    always @(posedge clk)
    begin : check_results
        result_word_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (result_words_due.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual 0x%08h / %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                due = result_words_due.pop_front();
                if (m_axis_tdata !== due.value)
                begin
                    $display("%0t: result_value expected 0x%08h, actual 0x%08h",
                             $time, due.value, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== due.status)
                begin
                    $display("%0t: error_code expected %0d, actual %0d",
                             $time, due.status, m_axis_tuser);
                    error_count++;
                end
                status_seen[int'(due.status)]++;
            end
        end
    end

    // Abort when neither side has moved a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 14;
        recv_idle_pct = 79;
        test_aligned_and_unaligned();
        test_bounds_and_modes();
        test_random_traffic(ITEMS_PER_PHASE);

        send_idle_pct = 79;
        recv_idle_pct = 14;
        test_random_traffic(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(ITEMS_PER_PHASE);
        s_axis_tvalid <= 1'b0;

        // Drain, then give stray words a chance to show up
        while (result_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d access words: %0d ok, %0d out of bounds, %0d illegal results",
                 words_sent, status_seen[0], status_seen[1], status_seen[2]);
        $display("Random traffic ran under sender/receiver idle mixes 14/79, 79/14, 0/0");
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
